@@ design/oal_pkg.sv @@
// ----------------------------------------------------------------------------
// oal_pkg: shared types and constants of the ordered array list
// Holds list depth, operation and status codes and the cell broadcast word.
// ----------------------------------------------------------------------------
`default_nettype none

package oal_pkg;

    localparam int unsigned ListDepth = 16;
    localparam int unsigned IdxW      = $clog2(ListDepth);
    localparam int unsigned CntW      = $clog2(ListDepth + 1);
    localparam int unsigned ValW      = 32;
    localparam int unsigned PlaceW    = 5;
    localparam int unsigned StatW     = 2;
    localparam int unsigned OpW       = 2;

    localparam int unsigned InBits    = OpW + ValW + PlaceW;
    localparam int unsigned InW       = ((InBits + 7) / 8) * 8;
    localparam int unsigned OutBits   = StatW + ValW + IdxW + CntW;
    localparam int unsigned OutW      = ((OutBits + 7) / 8) * 8;

    localparam logic [OpW-1:0] OpInsert  = 2'd0;
    localparam logic [OpW-1:0] OpDelete  = 2'd1;
    localparam logic [OpW-1:0] OpClear   = 2'd2;
    localparam logic [OpW-1:0] OpDisplay = 2'd3;

    localparam logic [StatW-1:0] StOk      = 2'd0;
    localparam logic [StatW-1:0] StFull    = 2'd1;
    localparam logic [StatW-1:0] StEmpty   = 2'd2;
    localparam logic [StatW-1:0] StMissing = 2'd3;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE,
        CELL_ROTATE
    } cell_cmd_t;

    // Broadcast to every cell of the row
    typedef struct packed {
        cell_cmd_t         cmd;
        logic [CntW-1:0]   pos;       // insert slot, already clamped to count
        logic [CntW-1:0]   hit;       // first matching slot on delete
        logic [CntW-1:0]   last_idx;  // final occupied slot on rotate
        logic [ValW-1:0]   value;
    } cell_bcast_t;

endpackage

`default_nettype wire

@@ design/ordered_array_list_unit.sv @@
// ----------------------------------------------------------------------------
// ordered_array_list_unit: bounded ordered list in a row of shift cells
// Insert, delete by value, clear and display over a list of 32-bit words.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on s_axis (s_tdata: opcode, item_value, place). Each
//   result word leaves on m_axis (m_tdata: status, entry_value, entry_index,
//   count_after), with m_tlast on the final word of an operation.
//   Insert, delete and clear complete in the cycle they are accepted: all
//   cells compare and shift in parallel, so the result word is registered at
//   that edge. A new word is accepted each cycle as long as no display is
//   streaming and the output register is empty or being drained.
//   Display of N entries streams N words, one a cycle unless m_tready
//   stalls, by rotating the cell row towards the head; after N rotations
//   the row is back in order. The input stalls until the last word is
//   sent (one word for an empty list). Reset clears the count, display
//   state and output valid; cell contents are kept, read only below count.
//   A stall on m_tready holds the output word and, through s_tready, the
//   input; a display in progress simply pauses its rotation.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_array_list_unit (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    // [1:0] opcode, [33:2] item_value, [38:34] place, [39] zero
    input  wire logic [oal_pkg::InW-1:0]    s_tdata,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    // [1:0] status, [33:2] entry_value, [37:34] entry_index,
    // [42:38] count_after, [47:43] zero
    output logic      [oal_pkg::OutW-1:0]   m_tdata,
    output logic                            m_tlast
);
    import oal_pkg::*;

    logic [OpW-1:0]    in_op;
    logic [ValW-1:0]   in_value;
    logic [PlaceW-1:0] in_place;

    assign in_op    = s_tdata[OpW-1:0];
    assign in_value = s_tdata[OpW +: ValW];
    assign in_place = s_tdata[OpW+ValW +: PlaceW];

    // control state
    logic [CntW-1:0] count_reg,   count_next;
    logic            disp_reg,    disp_next;
    logic [IdxW-1:0] didx_reg,    didx_next;
    logic            mvalid_reg,  mvalid_next;
    // output payload
    logic [StatW-1:0] mstat_reg,  mstat_next;
    logic [ValW-1:0]  mval_reg,   mval_next;
    logic [IdxW-1:0]  midx_reg,   midx_next;
    logic [CntW-1:0]  mcnt_reg,   mcnt_next;
    logic             mlast_reg,  mlast_next;

    cell_bcast_t               bcast;
    logic [ValW-1:0]           cell_data  [ListDepth];
    logic [ListDepth-1:0]      cell_match;
    logic [ValW-1:0]           left_in    [ListDepth];
    logic [ValW-1:0]           right_in   [ListDepth];

    logic            out_free;
    logic            in_acc;
    logic            found;
    logic [CntW-1:0] hit_idx;
    logic [CntW-1:0] last_slot;
    logic            disp_last;

    assign out_free = !mvalid_reg || m_tready;
    assign s_tready = !disp_reg && out_free;
    assign in_acc   = s_tvalid && s_tready;

    // first match below the count, lowest slot wins
    always_comb begin
        found   = 1'b0;
        hit_idx = '0;
        for (int i = ListDepth - 1; i >= 0; i--) begin
            if (cell_match[i] && (CntW'(i) < count_reg)) begin
                found   = 1'b1;
                hit_idx = CntW'(i);
            end
        end
    end

    assign last_slot = count_reg - CntW'(1);
    assign disp_last = ({1'b0, didx_reg} == last_slot);

    always_comb begin
        count_next  = count_reg;
        disp_next   = disp_reg;
        didx_next   = didx_reg;
        mvalid_next = mvalid_reg && !m_tready;
        mstat_next  = mstat_reg;
        mval_next   = mval_reg;
        midx_next   = midx_reg;
        mcnt_next   = mcnt_reg;
        mlast_next  = mlast_reg;

        bcast.cmd      = CELL_HOLD;
        bcast.pos      = (CntW'(in_place) > count_reg) ? count_reg : CntW'(in_place);
        bcast.hit      = hit_idx;
        bcast.last_idx = last_slot;
        bcast.value    = in_value;

        if (disp_reg) begin
            if (out_free) begin
                // emit the head, rotate the row by one
                bcast.cmd   = CELL_ROTATE;
                mvalid_next = 1'b1;
                mstat_next  = StOk;
                mval_next   = cell_data[0];
                midx_next   = didx_reg;
                mcnt_next   = count_reg;
                mlast_next  = disp_last;
                didx_next   = didx_reg + IdxW'(1);
                if (disp_last) begin
                    disp_next = 1'b0;
                end
            end
        end else if (in_acc) begin
            mvalid_next = 1'b1;
            mstat_next  = StOk;
            mval_next   = '0;
            midx_next   = '0;
            mlast_next  = 1'b1;
            case (in_op)
                OpInsert: begin
                    if (count_reg >= CntW'(ListDepth)) begin
                        mstat_next = StFull;
                    end else begin
                        bcast.cmd  = CELL_INSERT;
                        count_next = count_reg + CntW'(1);
                    end
                end
                OpDelete: begin
                    if (count_reg == '0) begin
                        mstat_next = StEmpty;
                    end else if (!found) begin
                        mstat_next = StMissing;
                    end else begin
                        bcast.cmd  = CELL_DELETE;
                        count_next = count_reg - CntW'(1);
                    end
                end
                OpClear: begin
                    count_next = '0;
                end
                OpDisplay: begin
                    if (count_reg == '0) begin
                        mstat_next = StEmpty;
                    end else begin
                        // no word this cycle; streaming starts next cycle
                        mvalid_next = 1'b0;
                        disp_next   = 1'b1;
                        didx_next   = '0;
                    end
                end
                default: mstat_next = StOk;
            endcase
            mcnt_next = count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            disp_reg   <= 1'b0;
            didx_reg   <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            count_reg  <= count_next;
            disp_reg   <= disp_next;
            didx_reg   <= didx_next;
            mvalid_reg <= mvalid_next;
        end
        mstat_reg <= mstat_next;
        mval_reg  <= mval_next;
        midx_reg  <= midx_next;
        mcnt_reg  <= mcnt_next;
        mlast_reg <= mlast_next;
    end

    // row of cells, neighbours wired in order; ends see zero
    for (genvar g = 0; g < ListDepth; g++) begin : g_cell
        if (g == 0) begin : g_left_end
            assign left_in[g] = '0;
        end else begin : g_left
            assign left_in[g] = cell_data[g-1];
        end
        if (g == ListDepth - 1) begin : g_right_end
            assign right_in[g] = '0;
        end else begin : g_right
            assign right_in[g] = cell_data[g+1];
        end

        oal_cell #(
            .CellIdx (g)
        ) u_cell (
            .aclk       (aclk),
            .bcast      (bcast),
            .key        (in_value),
            .left_data  (left_in[g]),
            .right_data (right_in[g]),
            .head_data  (cell_data[0]),
            .data       (cell_data[g]),
            .match      (cell_match[g])
        );
    end

    assign m_tvalid = mvalid_reg;
    assign m_tlast  = mlast_reg;
    assign m_tdata  = {(OutW - OutBits)'(0), mcnt_reg, midx_reg, mval_reg, mstat_reg};

endmodule

`default_nettype wire

@@ design/oal_cell.sv @@
// ----------------------------------------------------------------------------
// oal_cell: one slot of the list
// Holds one entry; takes its left or right neighbour, the head or a new value.
// ----------------------------------------------------------------------------
`default_nettype none

module oal_cell #(
    parameter int unsigned CellIdx = 0
) (
    input  wire logic                        aclk,
    input  wire oal_pkg::cell_bcast_t        bcast,
    input  wire logic [oal_pkg::ValW-1:0]    key,
    input  wire logic [oal_pkg::ValW-1:0]    left_data,
    input  wire logic [oal_pkg::ValW-1:0]    right_data,
    input  wire logic [oal_pkg::ValW-1:0]    head_data,
    output logic      [oal_pkg::ValW-1:0]    data,
    output logic                             match
);
    import oal_pkg::*;

    localparam logic [CntW-1:0] MyIdx = CntW'(CellIdx);

    logic [ValW-1:0] data_reg;
    logic [ValW-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        case (bcast.cmd)
            CELL_INSERT: begin
                if (MyIdx == bcast.pos) begin
                    data_next = bcast.value;
                end else if (MyIdx > bcast.pos) begin
                    data_next = left_data;
                end
            end
            CELL_DELETE: begin
                // close the gap from the hit onwards
                if (MyIdx >= bcast.hit) begin
                    data_next = right_data;
                end
            end
            CELL_ROTATE: begin
                if (MyIdx == bcast.last_idx) begin
                    data_next = head_data;
                end else if (MyIdx < bcast.last_idx) begin
                    data_next = right_data;
                end
            end
            default: data_next = data_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data  = data_reg;
    // compare against the raw search key, not the broadcast word
    assign match = (data_reg == key);

endmodule

`default_nettype wire
